// File: src/bcd_pkg.sv
// Shared widths, fixed-point constants and sideband types for the biquad coefficient designer.
package bcd_pkg;

    // Field widths of the request, the response and the sample rate register.
    localparam int FS_W    = 18;
    localparam int FC_W    = 17;
    localparam int COEFF_W = 32;
    localparam int PHASE_W = 32;

    // Q1.31 working format.
    localparam int Q31_W     = 32;
    localparam int Q31_SHIFT = 31;
    localparam logic [Q31_W-1:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [Q31_W-1:0] ROUND_Q31 = 32'h4000_0000;

    // Phase folding thresholds in turns, Q0.32.
    localparam logic [PHASE_W-1:0] PHASE_HALF    = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] PHASE_EIGHTH  = 32'h2000_0000;
    localparam int FOLD_W = 30;

    // Pi in Q2.31 (rounded) and 1/sqrt(2) in Q0.31.
    localparam int PI_W = 33;
    localparam logic [PI_W-1:0] PI_Q31 = 33'd6746518852;
    localparam int INV_SQRT2_W = 31;
    localparam logic [INV_SQRT2_W-1:0] INV_SQRT2_Q31 = 31'd1518500250;

    // Horner divisors for the sine and cosine series.
    localparam int TRIG_STEPS = 6;
    localparam int SIN_DIV [TRIG_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DIV [TRIG_STEPS] = '{132, 90, 56, 30, 12, 2};

    // Coefficient divider operand width (numerators and denominators).
    localparam int NUM_W = 33;

    // Sample rate after reset.
    localparam logic [FS_W-1:0] FS_RESET = 18'd48000;

    // Request flags that ride along the early part of the pipeline.
    typedef struct packed {
        logic kind;
        logic inv;
    } side_t;

    // Octant folding flags.
    typedef struct packed {
        logic cneg;
        logic swap;
    } fold_t;

    // Flags needed by the final sign and saturation stage.
    typedef struct packed {
        logic kind;
        logic inv;
        logic cneg;
    } tail_t;

endpackage

// File: src/bcd_req_if.sv
// Request channel: filter kind and cutoff frequency with valid/ready handshake.
interface bcd_req_if import bcd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [FC_W-1:0] cutoff_hz;

    modport source (output valid, output kind, output cutoff_hz, input ready);
    modport sink (input valid, input kind, input cutoff_hz, output ready);
endinterface

// File: src/bcd_rsp_if.sv
// Response channel: five biquad coefficients and the invalid flag with valid/ready handshake.
interface bcd_rsp_if import bcd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] b0_coeff;
    logic signed [COEFF_W-1:0] b1_coeff;
    logic signed [COEFF_W-1:0] b2_coeff;
    logic signed [COEFF_W-1:0] a1_coeff;
    logic signed [COEFF_W-1:0] a2_coeff;
    logic                      cutoff_invalid;

    modport source (output valid, output b0_coeff, output b1_coeff, output b2_coeff,
                    output a1_coeff, output a2_coeff, output cutoff_invalid, input ready);
    modport sink (input valid, input b0_coeff, input b1_coeff, input b2_coeff,
                  input a1_coeff, input a2_coeff, input cutoff_invalid, output ready);
endinterface

// File: src/bcd_delay.sv
// Enabled shift line that delays a payload word by DEPTH stages.
module bcd_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // Shift one place per advancing cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// File: src/bcd_mul31.sv
// Two-stage Q1.31 multiplier: registered product, then round-to-nearest and shift by 31.
module bcd_mul31 import bcd_pkg::*; #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic [Q31_W-1:0] y
);

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0]   prod_reg;
    logic [P_W-1:0]   prod_next;
    logic [P_W:0]     sum;
    logic [Q31_W-1:0] y_reg;
    logic [Q31_W-1:0] y_next;

    // Full product, then add half an LSB and drop 31 fraction bits.
    always_comb
    begin
        prod_next = P_W'(a) * P_W'(b);
        sum       = {1'b0, prod_reg} + (P_W+1)'(ROUND_Q31);
        y_next    = Q31_W'(sum >> Q31_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: src/bcd_trig_step.sv
// One Horner step of the series: t_out = 1 - mul31(x2, t_in) / DIVISOR, over five stages.
module bcd_trig_step import bcd_pkg::*; #(
    parameter int DIVISOR = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [Q31_W-1:0] x2_in,
    input  logic [Q31_W-1:0] t_in,
    output logic [Q31_W-1:0] x2_out,
    output logic [Q31_W-1:0] t_out
);

    // Reciprocal scaled so that it fits 32 bits; the estimate is low by at most one.
    localparam int SHIFT = Q31_SHIFT + $clog2(DIVISOR);
    localparam logic [Q31_W-1:0] RECIP = 32'((64'd1 << SHIFT) / DIVISOR);
    localparam int STEP_LAT = 5;

    logic [Q31_W-1:0]   v;
    logic [2*Q31_W-1:0] prod_reg;
    logic [Q31_W-1:0]   v_reg;
    logic [Q31_W-1:0]   q0;
    logic [Q31_W-1:0]   q0_reg;
    logic [Q31_W-1:0]   r_reg;
    logic [Q31_W-1:0]   t_reg;
    logic [Q31_W-1:0]   t_next;

    bcd_mul31 #(.A_W(Q31_W), .B_W(Q31_W)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (x2_in),
        .b   (t_in),
        .y   (v)
    );

    // Quotient estimate and its remainder, then a one-step correction.
    always_comb
    begin
        q0     = Q31_W'(prod_reg >> SHIFT);
        t_next = ONE_Q31 - (q0_reg + Q31_W'(r_reg >= Q31_W'(DIVISOR)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (2*Q31_W)'(v) * (2*Q31_W)'(RECIP);
            v_reg    <= v;
            q0_reg   <= q0;
            r_reg    <= v_reg - Q31_W'(q0 * Q31_W'(DIVISOR));
            t_reg    <= t_next;
        end
    end

    assign t_out = t_reg;

    // Keep the squared angle aligned with the step result.
    bcd_delay #(.WIDTH(Q31_W), .DEPTH(STEP_LAT)) u_x2_dly (
        .clk (clk),
        .en  (en),
        .d   (x2_in),
        .q   (x2_out)
    );

endmodule

// File: src/bcd_phase_div.sv
// Pipelined restoring divider for the phase: floor(cutoff * 2^32 / fs), one bit per stage.
module bcd_phase_div import bcd_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic [FC_W-1:0]    cutoff,
    input  logic [FS_W-1:0]    fs,
    output logic [PHASE_W-1:0] phase
);

    logic [FS_W-1:0]    rem_reg  [PHASE_W];
    logic [FS_W-1:0]    rem_next [PHASE_W];
    logic [PHASE_W-1:0] quo_reg  [PHASE_W];
    logic [PHASE_W-1:0] quo_next [PHASE_W];

    // Each stage doubles the remainder and subtracts fs when it fits.
    always_comb
    begin
        logic [FS_W-1:0]    rin;
        logic [PHASE_W-1:0] qin;
        logic [FS_W:0]      sh;
        logic               ge;
        for (int k = 0; k < PHASE_W; k++)
        begin
            if (k == 0)
            begin
                rin = FS_W'(cutoff);
                qin = '0;
            end
            else
            begin
                rin = rem_reg[k-1];
                qin = quo_reg[k-1];
            end
            sh          = {rin, 1'b0};
            ge          = (sh >= {1'b0, fs});
            rem_next[k] = ge ? FS_W'(sh - {1'b0, fs}) : FS_W'(sh);
            quo_next[k] = {qin[PHASE_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < PHASE_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign phase = quo_reg[PHASE_W-1];

endmodule

// File: src/bcd_coeff_div.sv
// Pipelined restoring divider for one coefficient: floor((num * 2^F + den/2) / den).
module bcd_coeff_div import bcd_pkg::*; #(
    parameter int FRAC_BITS = 30
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num,
    input  logic [NUM_W-1:0]     den,
    output logic [FRAC_BITS+1:0] quo
);

    // The ratio never exceeds two, so F+2 quotient bits cover it.
    localparam int Q_W   = FRAC_BITS + 2;
    localparam int DVD_W = NUM_W + FRAC_BITS + 1;

    logic [DVD_W-1:0] dvd;
    logic [NUM_W-1:0] rem_reg  [Q_W];
    logic [NUM_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   low_reg  [Q_W];
    logic [Q_W-1:0]   low_next [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [NUM_W-1:0] den_reg  [Q_W];

    // Rounded dividend; its upper part is the starting remainder.
    assign dvd = (DVD_W'(num) << FRAC_BITS) + DVD_W'(den >> 1);

    // Each stage brings down one dividend bit and resolves one quotient bit.
    always_comb
    begin
        logic [NUM_W-1:0] rin;
        logic [Q_W-1:0]   lin;
        logic [Q_W-1:0]   qin;
        logic [NUM_W-1:0] din;
        logic [NUM_W:0]   sh;
        logic             ge;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                rin = NUM_W'(dvd >> Q_W);
                lin = dvd[Q_W-1:0];
                qin = '0;
                din = den;
            end
            else
            begin
                rin = rem_reg[k-1];
                lin = low_reg[k-1];
                qin = quo_reg[k-1];
                din = den_reg[k-1];
            end
            sh          = {rin, lin[Q_W-1]};
            ge          = (sh >= {1'b0, din});
            rem_next[k] = ge ? NUM_W'(sh - {1'b0, din}) : NUM_W'(sh);
            low_next[k] = lin << 1;
            quo_next[k] = {qin[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
            end
            den_reg[0] <= den;
            for (int k = 1; k < Q_W; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

// File: src/biquad_coeff_designer_unit.sv
// Throughput: one request beat per cycle while response beats are taken; the dividers resolve
// one bit per stage and each Horner step of the sine and cosine series takes five stages, all
// fully pipelined. The whole pipeline advances together and holds while a response beat
// is not taken. Reset clears all valid bits and sets the sample rate register to 48000 Hz.
module biquad_coeff_designer_unit import bcd_pkg::*; #(
    parameter int COEFF_FRAC_BITS = 30
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [FS_W-1:0] cfg_wr_data,
    bcd_req_if.sink         req,
    bcd_rsp_if.source       rsp
);

    localparam int Q_W = COEFF_FRAC_BITS + 2;
    localparam int LAT = 76 + COEFF_FRAC_BITS;

    // Signed, saturated coefficient from a rounded quotient magnitude.
    function automatic logic [COEFF_W-1:0] sat_coeff(input logic [Q_W-1:0] m, input logic neg);
        logic [COEFF_W:0] mx;
        logic [COEFF_W:0] mm;
        logic [COEFF_W-1:0] res;
        mx = (COEFF_W+1)'(m);
        if (!neg)
        begin
            if (mx > (COEFF_W+1)'(32'h7FFF_FFFF))
                res = 32'h7FFF_FFFF;
            else
                res = mx[COEFF_W-1:0];
        end
        else
        begin
            if (mx > (COEFF_W+1)'(32'h8000_0000))
                mm = (COEFF_W+1)'(32'h8000_0000);
            else
                mm = mx;
            res = (~mm[COEFF_W-1:0]) + 32'd1;
        end
        return res;
    endfunction

    logic            en;
    logic [LAT-1:0]  valid_reg;
    logic [FS_W-1:0] sample_rate_reg;

    // Global advance: the output register is free or being taken.
    assign en        = !valid_reg[LAT-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = valid_reg[LAT-1];

    // Control state: sample rate register and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= FS_RESET;
            valid_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                sample_rate_reg <= cfg_wr_data;
            if (en)
                valid_reg <= {valid_reg[LAT-2:0], req.valid};
        end
    end

    // Input stage: capture the request and flag a zero cutoff or one at or above Nyquist.
    logic            kind_reg;
    logic [FC_W-1:0] cutoff_reg;
    logic            inv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg   <= req.kind;
            cutoff_reg <= req.cutoff_hz;
            inv_reg    <= (req.cutoff_hz == '0) || ({req.cutoff_hz, 1'b0} >= sample_rate_reg);
        end
    end

    side_t side_s1;
    side_t side_s72;

    assign side_s1 = '{kind: kind_reg, inv: inv_reg};

    bcd_delay #(.WIDTH($bits(side_t)), .DEPTH(71)) u_side_dly (
        .clk (clk),
        .en  (en),
        .d   (side_s1),
        .q   (side_s72)
    );

    // Phase in turns.
    logic [PHASE_W-1:0] phase;

    bcd_phase_div u_phase (
        .clk    (clk),
        .en     (en),
        .cutoff (cutoff_reg),
        .fs     (sample_rate_reg),
        .phase  (phase)
    );

    // Fold the phase into the first octant.
    logic [PHASE_W-1:0] p1;
    logic [PHASE_W-1:0] p2;
    logic [FOLD_W-1:0]  fold_p_reg;
    fold_t              fold_reg;
    fold_t              fold_next;

    always_comb
    begin
        fold_next.cneg = (phase > PHASE_QUARTER);
        p1             = fold_next.cneg ? (PHASE_HALF - phase) : phase;
        fold_next.swap = (p1 > PHASE_EIGHTH);
        p2             = fold_next.swap ? (PHASE_QUARTER - p1) : p1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_p_reg <= FOLD_W'(p2);
            fold_reg   <= fold_next;
        end
    end

    // Angle in radians and its square.
    logic [Q31_W-1:0] x;
    logic [Q31_W-1:0] x2;
    logic [Q31_W-1:0] x_s68;

    bcd_mul31 #(.A_W(FOLD_W), .B_W(PI_W)) u_angle (
        .clk (clk),
        .en  (en),
        .a   (fold_p_reg),
        .b   (PI_Q31),
        .y   (x)
    );

    bcd_mul31 #(.A_W(Q31_W), .B_W(Q31_W)) u_square (
        .clk (clk),
        .en  (en),
        .a   (x),
        .b   (x),
        .y   (x2)
    );

    bcd_delay #(.WIDTH(Q31_W), .DEPTH(32)) u_x_dly (
        .clk (clk),
        .en  (en),
        .d   (x),
        .q   (x_s68)
    );

    // Sine and cosine Horner chains.
    logic [Q31_W-1:0] sin_t  [TRIG_STEPS+1];
    logic [Q31_W-1:0] sin_x2 [TRIG_STEPS+1];
    logic [Q31_W-1:0] cos_t  [TRIG_STEPS+1];
    logic [Q31_W-1:0] cos_x2 [TRIG_STEPS+1];

    assign sin_t[0]  = ONE_Q31;
    assign sin_x2[0] = x2;
    assign cos_t[0]  = ONE_Q31;
    assign cos_x2[0] = x2;

    for (genvar i = 0; i < TRIG_STEPS; i++)
    begin : g_trig
        bcd_trig_step #(.DIVISOR(SIN_DIV[i])) u_sin_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (sin_x2[i]),
            .t_in   (sin_t[i]),
            .x2_out (sin_x2[i+1]),
            .t_out  (sin_t[i+1])
        );

        bcd_trig_step #(.DIVISOR(COS_DIV[i])) u_cos_step (
            .clk    (clk),
            .en     (en),
            .x2_in  (cos_x2[i]),
            .t_in   (cos_t[i]),
            .x2_out (cos_x2[i+1]),
            .t_out  (cos_t[i+1])
        );
    end

    // Final sine multiply; cosine waits alongside.
    logic [Q31_W-1:0] sin_s70;
    logic [Q31_W-1:0] cos_s70;

    bcd_mul31 #(.A_W(Q31_W), .B_W(Q31_W)) u_sin_fin (
        .clk (clk),
        .en  (en),
        .a   (x_s68),
        .b   (sin_t[TRIG_STEPS]),
        .y   (sin_s70)
    );

    bcd_delay #(.WIDTH(Q31_W), .DEPTH(2)) u_cos_dly (
        .clk (clk),
        .en  (en),
        .d   (cos_t[TRIG_STEPS]),
        .q   (cos_s70)
    );

    // Undo the octant swap, then scale sine by 1/sqrt(2).
    fold_t            fold_s70;
    fold_t            fold_s72;
    logic [Q31_W-1:0] s_s70;
    logic [Q31_W-1:0] cabs_s70;
    logic [Q31_W-1:0] cabs_s72;
    logic [Q31_W-1:0] h_s72;

    bcd_delay #(.WIDTH($bits(fold_t)), .DEPTH(36)) u_fold_dly (
        .clk (clk),
        .en  (en),
        .d   (fold_reg),
        .q   (fold_s70)
    );

    assign s_s70    = fold_s70.swap ? cos_s70 : sin_s70;
    assign cabs_s70 = fold_s70.swap ? sin_s70 : cos_s70;

    bcd_mul31 #(.A_W(Q31_W), .B_W(INV_SQRT2_W)) u_half (
        .clk (clk),
        .en  (en),
        .a   (s_s70),
        .b   (INV_SQRT2_Q31),
        .y   (h_s72)
    );

    bcd_delay #(.WIDTH(Q31_W), .DEPTH(2)) u_cabs_dly (
        .clk (clk),
        .en  (en),
        .d   (cabs_s70),
        .q   (cabs_s72)
    );

    bcd_delay #(.WIDTH($bits(fold_t)), .DEPTH(2)) u_fold2_dly (
        .clk (clk),
        .en  (en),
        .d   (fold_s70),
        .q   (fold_s72)
    );

    // Denominators and numerators for the four dividers.
    logic [NUM_W-1:0] onem;
    logic [NUM_W-1:0] onep;
    logic [NUM_W-1:0] d_reg;
    logic [NUM_W-1:0] d2_reg;
    logic [NUM_W-1:0] numb_reg;
    logic [NUM_W-1:0] numa1_reg;
    logic [NUM_W-1:0] numa2_reg;
    tail_t            tail_reg;
    tail_t            tail_out;

    always_comb
    begin
        if (fold_s72.cneg)
        begin
            onem = NUM_W'(ONE_Q31) + NUM_W'(cabs_s72);
            onep = NUM_W'(ONE_Q31) - NUM_W'(cabs_s72);
        end
        else
        begin
            onem = NUM_W'(ONE_Q31) - NUM_W'(cabs_s72);
            onep = NUM_W'(ONE_Q31) + NUM_W'(cabs_s72);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= NUM_W'(ONE_Q31) + NUM_W'(h_s72);
            d2_reg    <= (NUM_W'(ONE_Q31) + NUM_W'(h_s72)) << 1;
            numb_reg  <= side_s72.kind ? onep : onem;
            numa1_reg <= {cabs_s72, 1'b0};
            numa2_reg <= NUM_W'(ONE_Q31) - NUM_W'(h_s72);
            tail_reg  <= '{kind: side_s72.kind, inv: side_s72.inv, cneg: fold_s72.cneg};
        end
    end

    // Coefficient dividers.
    logic [Q_W-1:0] m_b0;
    logic [Q_W-1:0] m_b1;
    logic [Q_W-1:0] m_a1;
    logic [Q_W-1:0] m_a2;

    bcd_coeff_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_b0 (
        .clk (clk), .en (en), .num (numb_reg), .den (d2_reg), .quo (m_b0)
    );

    bcd_coeff_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_b1 (
        .clk (clk), .en (en), .num (numb_reg), .den (d_reg), .quo (m_b1)
    );

    bcd_coeff_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_a1 (
        .clk (clk), .en (en), .num (numa1_reg), .den (d_reg), .quo (m_a1)
    );

    bcd_coeff_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_a2 (
        .clk (clk), .en (en), .num (numa2_reg), .den (d_reg), .quo (m_a2)
    );

    bcd_delay #(.WIDTH($bits(tail_t)), .DEPTH(COEFF_FRAC_BITS + 2)) u_tail_dly (
        .clk (clk),
        .en  (en),
        .d   (tail_reg),
        .q   (tail_out)
    );

    // Output register: sign, saturate, and zero rejected requests.
    logic [COEFF_W-1:0] b0_reg;
    logic [COEFF_W-1:0] b1_reg;
    logic [COEFF_W-1:0] a1_reg;
    logic [COEFF_W-1:0] a2_reg;
    logic               inv_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (tail_out.inv)
            begin
                b0_reg <= '0;
                b1_reg <= '0;
                a1_reg <= '0;
                a2_reg <= '0;
            end
            else
            begin
                b0_reg <= sat_coeff(m_b0, 1'b0);
                b1_reg <= sat_coeff(m_b1, tail_out.kind);
                a1_reg <= sat_coeff(m_a1, !tail_out.cneg);
                a2_reg <= sat_coeff(m_a2, 1'b0);
            end
            inv_out_reg <= tail_out.inv;
        end
    end

    assign rsp.b0_coeff       = b0_reg;
    assign rsp.b1_coeff       = b1_reg;
    assign rsp.b2_coeff       = b0_reg;
    assign rsp.a1_coeff       = a1_reg;
    assign rsp.a2_coeff       = a2_reg;
    assign rsp.cutoff_invalid = inv_out_reg;

endmodule

// File: tb/biquad_coeff_designer_unit_tb.sv
// Self-checking testbench for the Butterworth biquad coefficient designer.
`timescale 1ns / 1ps

module biquad_coeff_designer_unit_tb;
    import bcd_pkg::*;

    localparam int FRAC = 30;
    localparam int LATENCY = 76 + FRAC;

    // One request and one expected set of coefficients.
    typedef struct packed {
        logic            kind;
        logic [FC_W-1:0] cutoff_hz;
    } request_t;

    typedef struct packed {
        logic [COEFF_W-1:0] b0;
        logic [COEFF_W-1:0] b1;
        logic [COEFF_W-1:0] b2;
        logic [COEFF_W-1:0] a1;
        logic [COEFF_W-1:0] a2;
        logic               invalid;
    } coeffs_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [FS_W-1:0] cfg_wr_data;

    bcd_req_if req ();
    bcd_rsp_if rsp ();

    biquad_coeff_designer_unit #(.COEFF_FRAC_BITS(FRAC)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req(req.sink),
        .rsp(rsp.source)
    );

    request_t pending_requests[$];
    coeffs_t  expected_coeffs[$];
    logic [FS_W-1:0] sample_rate;
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    bit in_taken;

    // Q1.31 rounded product.
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'h4000_0000) >> 31;
    endfunction

    // Horner evaluation of the sine or cosine series.
    function automatic logic [63:0] series(logic [63:0] x, bit is_sin);
        int sdiv[6];
        int cdiv[6];
        logic [63:0] x2;
        logic [63:0] t;
        sdiv = '{156, 110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        x2 = qmul(x, x);
        t = 64'h8000_0000;
        for (int i = 0; i < 6; i++)
            t = 64'h8000_0000 - qmul(x2, t) / (is_sin ? sdiv[i] : cdiv[i]);
        return is_sin ? qmul(x, t) : t;
    endfunction

    // Rounded, signed and saturated quotient in the coefficient format.
    function automatic logic [31:0] scale_div(logic [63:0] num, bit neg, logic [63:0] den);
        logic [63:0] m;
        m = ((num << FRAC) + den / 2) / den;
        if (!neg)
            return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        if (m > 64'h8000_0000)
            m = 64'h8000_0000;
        return 32'(64'd0 - m);
    endfunction

    // Computes the coefficients for one request at the current sample rate.
    function automatic coeffs_t design_biquad(request_t r, logic [FS_W-1:0] fs);
        coeffs_t c;
        logic [63:0] p, x, sn, cs, s, cabs, h, d, onem, onep;
        bit cneg, swap;
        c = '0;
        cneg = 0;
        swap = 0;
        if (r.cutoff_hz == 0 || 2 * 64'(r.cutoff_hz) >= 64'(fs))
        begin
            c.invalid = 1'b1;
            return c;
        end
        p = (64'(r.cutoff_hz) << 32) / 64'(fs);
        if (p > 64'h4000_0000)
        begin
            p = 64'h8000_0000 - p;
            cneg = 1;
        end
        if (p > 64'h2000_0000)
        begin
            p = 64'h4000_0000 - p;
            swap = 1;
        end
        x = (p * 64'd6746518852 + 64'h4000_0000) >> 31;
        sn = series(x, 1);
        cs = series(x, 0);
        s = swap ? cs : sn;
        cabs = swap ? sn : cs;
        h = qmul(s, 64'd1518500250);
        d = 64'h8000_0000 + h;
        onem = cneg ? 64'h8000_0000 + cabs : 64'h8000_0000 - cabs;
        onep = cneg ? 64'h8000_0000 - cabs : 64'h8000_0000 + cabs;
        if (!r.kind)
        begin
            c.b0 = scale_div(onem, 0, 2 * d);
            c.b1 = scale_div(onem, 0, d);
        end
        else
        begin
            c.b0 = scale_div(onep, 0, 2 * d);
            c.b1 = scale_div(onep, 1, d);
        end
        c.b2 = c.b0;
        c.a1 = scale_div(2 * cabs, !cneg, d);
        c.a2 = scale_div(64'h8000_0000 - h, 0, d);
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: presents queued requests at the falling edge.
    always @(negedge clk)
    begin
        if (!req.valid || in_taken)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req.valid <= 1'b1;
                {req.kind, req.cutoff_hz} <= pending_requests.pop_front();
            end
            else
                req.valid <= 1'b0;
        end
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: checks each response beat against the oldest expectation
    // and records the expectation for each request beat.
    always @(posedge clk)
    begin
        coeffs_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_coeffs.size() == 0)
            begin
                $error("unexpected response beat");
                errors++;
            end
            else
            begin
                e = expected_coeffs.pop_front();
                if (rsp.b0_coeff !== e.b0)
                begin
                    $error("b0_coeff expected %h actual %h", e.b0, rsp.b0_coeff);
                    errors++;
                end
                if (rsp.b1_coeff !== e.b1)
                begin
                    $error("b1_coeff expected %h actual %h", e.b1, rsp.b1_coeff);
                    errors++;
                end
                if (rsp.b2_coeff !== e.b2)
                begin
                    $error("b2_coeff expected %h actual %h", e.b2, rsp.b2_coeff);
                    errors++;
                end
                if (rsp.a1_coeff !== e.a1)
                begin
                    $error("a1_coeff expected %h actual %h", e.a1, rsp.a1_coeff);
                    errors++;
                end
                if (rsp.a2_coeff !== e.a2)
                begin
                    $error("a2_coeff expected %h actual %h", e.a2, rsp.a2_coeff);
                    errors++;
                end
                if (rsp.cutoff_invalid !== e.invalid)
                begin
                    $error("cutoff_invalid expected %b actual %b", e.invalid,
                           rsp.cutoff_invalid);
                    errors++;
                end
            end
        end
        in_taken = rst_n && req.valid && req.ready;
        if (in_taken)
            expected_coeffs.push_back(design_biquad({req.kind, req.cutoff_hz}, sample_rate));
    end

    // Waits until every queued request is taken and every response has arrived.
    task automatic drain();
        while (pending_requests.size() > 0 || req.valid || expected_coeffs.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Writes the sample rate register while the block is idle.
    task automatic set_sample_rate(logic [FS_W-1:0] fs);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= fs;
        sample_rate = fs;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly valid cutoffs, some at or above Nyquist, and a few raw values.
    task automatic queue_random(int count, logic [FS_W-1:0] fs);
        request_t r;
        int over;
        repeat (count)
        begin
            r.kind = 1'($urandom_range(1));
            case ($urandom_range(9))
                0: r.cutoff_hz = FC_W'($urandom);
                1:
                begin
                    over = int'(fs / 2) + int'($urandom_range(3));
                    r.cutoff_hz = (over > 131071) ? FC_W'(131071) : FC_W'(over);
                end
                2: r.cutoff_hz = FC_W'($urandom_range(3));
                default: r.cutoff_hz = FC_W'($urandom_range(1, (fs - 1) / 2));
            endcase
            pending_requests.push_back(r);
        end
    endtask

    int rates[6];
    int idle_send[4];
    int idle_recv[4];

    initial
    begin
        rates = '{48000, 8000, 192000, 44100, 262143, 96000};
        idle_send = '{0, 61, 0, 24};
        idle_recv = '{0, 0, 61, 24};
        errors = 0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sample_rate = FS_RESET;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.kind = 1'b0;
        req.cutoff_hz = '0;
        rsp.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the reset sample rate: edges, Nyquist and both kinds.
        for (int k = 0; k < 2; k++)
        begin
            pending_requests.push_back({k[0], 17'd0});
            pending_requests.push_back({k[0], 17'd1});
            pending_requests.push_back({k[0], 17'd1000});
            pending_requests.push_back({k[0], 17'd6000});
            pending_requests.push_back({k[0], 17'd12000});
            pending_requests.push_back({k[0], 17'd18000});
            pending_requests.push_back({k[0], 17'd23999});
            pending_requests.push_back({k[0], 17'd24000});
            pending_requests.push_back({k[0], 17'd131071});
            pending_requests.push_back({k[0], 17'h15555});
            pending_requests.push_back({k[0], 17'h0AAAA});
        end
        drain();

        // Random phases across sample rates and idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_sample_rate(FS_W'(rates[ph % 6]));
            send_idle_pct = idle_send[ph % 4];
            recv_stall_pct = idle_recv[ph % 4];
            queue_random(30, FS_W'(rates[ph % 6]));
            // Pause the sender until all results are in, then continue.
            while (pending_requests.size() > 0 || req.valid) @(posedge clk);
            while (expected_coeffs.size() > 0) @(posedge clk);
            queue_random(30, FS_W'(rates[ph % 6]));
            drain();
        end
        // Zero sample rate: every cutoff is invalid.
        set_sample_rate('0);
        queue_random(10, '0);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
